### hw/rtl/ipf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipf_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ENTRY_W   = 4;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PROTO_W   = 8;
  localparam int unsigned SA_W      = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ENTRIES_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BIND   = 2'd2;

  localparam logic TRANSPORT = 1'b0;
  localparam logic TUNNEL    = 1'b1;

  localparam logic [PROTO_W-1:0] PROTO_WILDCARD = 8'd255;

  localparam logic [STATUS_W-1:0] BIND_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] BIND_NEW     = 2'd1;
  localparam logic [STATUS_W-1:0] BIND_ALREADY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANY_PROTOCOL   = 2'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry_index;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  mask_a;
    logic [ADDR_W-1:0]  addr_b;
    logic [ADDR_W-1:0]  mask_b;
    logic [PROTO_W-1:0] upper_protocol;
    logic [PROTO_W-1:0] ipsec_protocol;
    logic               mode;
    logic [ADDR_W-1:0]  tunnel_src;
    logic [ADDR_W-1:0]  tunnel_dst;
    logic [SA_W-1:0]    sa_handle;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  src_care;
    logic [ADDR_W-1:0]  dst;
    logic [ADDR_W-1:0]  dst_care;
    logic [PROTO_W-1:0] upper_proto;
    logic [PROTO_W-1:0] ipsec_proto;
    logic               mode;
    logic [ADDR_W-1:0]  tunnel_src;
    logic [ADDR_W-1:0]  tunnel_dst;
  } rule_t;

  typedef struct packed {
    logic                hit;
    logic [ENTRY_W-1:0]  match_index;
    logic [STATUS_W-1:0] bind_status;
    logic [SA_W-1:0]     first_sa;
  } result_t;

  typedef struct packed {
    logic capture;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } stat_t;

  function automatic logic [ADDR_W-1:0] swap32(input logic [ADDR_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ipf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipf_item_if;
  import ipf_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ENTRY_W-1:0] entry_index;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  mask_a;
  logic [ADDR_W-1:0]  addr_b;
  logic [ADDR_W-1:0]  mask_b;
  logic [PROTO_W-1:0] upper_protocol;
  logic [PROTO_W-1:0] ipsec_protocol;
  logic               mode;
  logic [ADDR_W-1:0]  tunnel_src;
  logic [ADDR_W-1:0]  tunnel_dst;
  logic [SA_W-1:0]    sa_handle;

  modport source (
    output valid, func, entry_index, addr_a, mask_a, addr_b, mask_b, upper_protocol,
           ipsec_protocol, mode, tunnel_src, tunnel_dst, sa_handle,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, addr_a, mask_a, addr_b, mask_b, upper_protocol,
           ipsec_protocol, mode, tunnel_src, tunnel_dst, sa_handle,
    output ready
  );
endinterface

interface ipf_result_if;
  import ipf_pkg::*;
  logic                valid;
  logic                ready;
  logic                hit;
  logic [ENTRY_W-1:0]  match_index;
  logic [STATUS_W-1:0] bind_status;
  logic [SA_W-1:0]     first_sa;

  modport source (output valid, hit, match_index, bind_status, first_sa, input ready);
  modport sink (input valid, hit, match_index, bind_status, first_sa, output ready);
endinterface

interface ipf_cfg_if;
  import ipf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ipsec_policy_first_match.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered policy table of 16 rules with first-match lookup and SA binding. One item is
// handled at a time: after its transfer, the table is scanned one rule per cycle starting
// at slot 0 until the first match or until n rules have been tried, where n is
// entries_in_use capped at 16; a load or an unknown function gives its result without a
// scan. The next item can be taken the cycle after the result is registered; the scan rate
// is set by the single rule read port that the scan walks. The result register lets a
// new item start while the previous result still waits; if that result is still
// waiting when the scan ends, the scan holds until it has been taken.
// Configuration is always ready and takes effect as soon as it is written, also on a scan
// in progress; rules must be loaded before they are scanned.
module ipsec_policy_first_match (
  input  logic clk_i,
  input  logic rst_ni,
  ipf_item_if.sink     in_i,
  ipf_result_if.source out_o,
  ipf_cfg_if.sink      cfg_i
);
  import ipf_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  item_t   item;
  result_t res;

  assign item = '{
    func:           in_i.func,
    entry_index:    in_i.entry_index,
    addr_a:         in_i.addr_a,
    mask_a:         in_i.mask_a,
    addr_b:         in_i.addr_b,
    mask_b:         in_i.mask_b,
    upper_protocol: in_i.upper_protocol,
    ipsec_protocol: in_i.ipsec_protocol,
    mode:           in_i.mode,
    tunnel_src:     in_i.tunnel_src,
    tunnel_dst:     in_i.tunnel_dst,
    sa_handle:      in_i.sa_handle
  };

  assign cfg_i.ready       = 1'b1;
  assign out_o.hit         = res.hit;
  assign out_o.match_index = res.match_index;
  assign out_o.bind_status = res.bind_status;
  assign out_o.first_sa    = res.first_sa;

  ipf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ipf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .item_i      (item),
    .res_o       (res),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data)
  );

endmodule

`default_nettype wire

### hw/rtl/ipf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ipf_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ipf_pkg::cmd_t                 cmd_i,
  output ipf_pkg::stat_t                stat_o,
  input  ipf_pkg::item_t                item_i,
  output ipf_pkg::result_t              res_o,
  input  logic                          cfg_we_i,
  input  logic [ipf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ipf_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import ipf_pkg::*;

  item_t                item_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ENTRIES_W-1:0] entries_q;
  logic [PROTO_W-1:0]   any_proto_q;
  rule_t                rule_q [TABLE_DEPTH];
  logic [SA_W-1:0]      first_sa_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] bound_q;
  result_t              res_q, res_d;

  logic [IDX_W-1:0]  cur_idx;
  rule_t             cur;
  logic              cur_bound;
  logic [SA_W-1:0]   cur_sa;
  logic [CNT_W-1:0]  limit;
  logic              scan_end;
  logic [ADDR_W-1:0] pa, pb;
  logic              addr_ok, lookup_ok, bind_ok;
  logic              is_lookup, is_bind, is_load, match;
  logic              load_ok;

  assign cur_idx   = cnt_q[IDX_W-1:0];
  assign cur       = rule_q[cur_idx];
  assign cur_bound = bound_q[cur_idx];
  assign cur_sa    = first_sa_q[cur_idx];

  assign is_load   = (item_q.func == FUNC_LOAD);
  assign is_lookup = (item_q.func == FUNC_LOOKUP);
  assign is_bind   = (item_q.func == FUNC_BIND);
  assign load_ok   = is_load && ({1'b0, item_q.entry_index} < (ENTRY_W + 1)'(TABLE_DEPTH));

  always_comb begin
    limit = (CNT_W'(entries_q) > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entries_q);
    scan_end = (cnt_q >= limit);
    pa = is_lookup ? swap32(item_q.addr_a) : item_q.addr_a;
    pb = is_lookup ? swap32(item_q.addr_b) : item_q.addr_b;
    addr_ok = ((pa & cur.src_care) == (cur.src & cur.src_care)) &&
              ((pb & cur.dst_care) == (cur.dst & cur.dst_care));
    lookup_ok = addr_ok && ((cur.upper_proto == any_proto_q) ||
                            (cur.upper_proto == item_q.upper_protocol));
    bind_ok = ((cur.mode == TUNNEL) ? ((item_q.addr_a == cur.tunnel_src) &&
                                       (item_q.addr_b == cur.tunnel_dst))
                                    : addr_ok) &&
              (cur.ipsec_proto == item_q.ipsec_protocol);
    match = !scan_end && ((is_lookup && lookup_ok) || (is_bind && bind_ok));
  end

  assign stat_o.done = !(is_lookup || is_bind) || scan_end || match;
  assign stat_o.hit  = match;

  always_comb begin
    res_d = '0;
    if (match) begin
      res_d.hit         = 1'b1;
      res_d.match_index = ENTRY_W'(cur_idx);
      if (is_bind) begin
        res_d.bind_status = cur_bound ? BIND_ALREADY : BIND_NEW;
        res_d.first_sa    = cur_bound ? cur_sa : item_q.sa_handle;
      end else begin
        res_d.first_sa = cur_bound ? cur_sa : '0;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.capture) begin
      cnt_d = '0;
    end else if (cmd_i.advance) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      entries_q   <= '0;
      any_proto_q <= PROTO_WILDCARD;
      bound_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENTRIES_IN_USE: entries_q   <= cfg_data_i[ENTRIES_W-1:0];
          CFG_ANY_PROTOCOL:   any_proto_q <= cfg_data_i[PROTO_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        if (load_ok) begin
          bound_q[item_q.entry_index[IDX_W-1:0]] <= 1'b0;
        end else if (is_bind && match && !cur_bound) begin
          bound_q[cur_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
      if (load_ok) begin
        rule_q[item_q.entry_index[IDX_W-1:0]] <= '{
          src:         item_q.addr_a,
          src_care:    item_q.mask_a,
          dst:         item_q.addr_b,
          dst_care:    item_q.mask_b,
          upper_proto: item_q.upper_protocol,
          ipsec_proto: item_q.ipsec_protocol,
          mode:        item_q.mode,
          tunnel_src:  item_q.tunnel_src,
          tunnel_dst:  item_q.tunnel_dst
        };
      end
      if (is_bind && match && !cur_bound) begin
        first_sa_q[cur_idx] <= item_q.sa_handle;
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/ipf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ipf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ipf_pkg::cmd_t  cmd_o,
  input  ipf_pkg::stat_t stat_i
);
  import ipf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free      = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;

  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.advance = (state_q == ST_SCAN) && !stat_i.done;
  assign cmd_o.finish  = (state_q == ST_SCAN) && stat_i.done && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cmd_o.capture) state_d = ST_SCAN;
      ST_SCAN: if (cmd_o.finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.advance, cmd_o.finish}))
    else $error("controller commands overlap");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished item not presented");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && !cmd_o.finish) |=> (state_q == ST_SCAN))
    else $error("scan left without a result");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && stat_i.hit) |-> stat_i.done)
    else $error("hit without scan completion");

  a_idle_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && !in_valid_i) |=> (state_q == ST_IDLE))
    else $error("scan started without a transfer");

endmodule

`default_nettype wire

### bench/ipsec_policy_first_match_tb.sv
`timescale 1ns / 1ps

module ipsec_policy_first_match_tb;
  import ipf_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = TABLE_DEPTH + 4;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam result_t     NO_MATCH      = '0;
  localparam logic [PROTO_W-1:0] PROTO_POOL [4] = '{8'd6, 8'd17, 8'd50, 8'd51};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    item_t                item;
    bit                   typed;
    result_t              want;
    logic [ENTRIES_W-1:0] entries;
    logic [PROTO_W-1:0]   any_code;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ipf_item_if   item_if ();
  ipf_result_if res_if ();
  ipf_cfg_if    cfg_if ();

  ipsec_policy_first_match dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  rule_t                policy_rule [TABLE_DEPTH];
  bit                   policy_bound [TABLE_DEPTH];
  logic [SA_W-1:0]      policy_first_sa [TABLE_DEPTH];
  logic [ENTRIES_W-1:0] scan_entries;
  logic [PROTO_W-1:0]   wildcard_proto;
  logic [ADDR_W-1:0]    addr_pool [4];
  result_t              pending_results [$];
  int unsigned          err_count = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          rx_hold = 0;
  bit                   rx_calm = 1'b0;
  bit                   tx_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] byte_reverse(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int k = 0; k < 4; k++) r[8*k +: 8] = v[8*(3-k) +: 8];
    return r;
  endfunction

  function automatic bit addr_in_rule(input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] b,
                                      input rule_t r);
    return ((a & r.src_care) == (r.src & r.src_care)) &&
           ((b & r.dst_care) == (r.dst & r.dst_care));
  endfunction

  // first-match scan over the policy table, updating bind state
  function automatic result_t predict_policy(input item_t it);
    result_t           res;
    int unsigned       n;
    logic [ADDR_W-1:0] pkt_src;
    logic [ADDR_W-1:0] pkt_dst;
    bit                m;
    res = NO_MATCH;
    n = (32'(scan_entries) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(scan_entries);
    pkt_src = byte_reverse(it.addr_a);
    pkt_dst = byte_reverse(it.addr_b);
    case (it.func)
      FUNC_LOAD: begin
        policy_rule[it.entry_index] = '{src: it.addr_a, src_care: it.mask_a, dst: it.addr_b,
                                        dst_care: it.mask_b, upper_proto: it.upper_protocol,
                                        ipsec_proto: it.ipsec_protocol, mode: it.mode,
                                        tunnel_src: it.tunnel_src, tunnel_dst: it.tunnel_dst};
        policy_bound[it.entry_index] = 1'b0;
      end
      FUNC_LOOKUP: begin
        for (int i = 0; i < n; i++) begin
          if (!res.hit && addr_in_rule(pkt_src, pkt_dst, policy_rule[i]) &&
              (policy_rule[i].upper_proto == wildcard_proto ||
               policy_rule[i].upper_proto == it.upper_protocol)) begin
            res.hit = 1'b1;
            res.match_index = ENTRY_W'(i);
            res.first_sa = policy_bound[i] ? policy_first_sa[i] : '0;
          end
        end
      end
      FUNC_BIND: begin
        for (int i = 0; i < n; i++) begin
          if (policy_rule[i].mode == TUNNEL)
            m = it.addr_a == policy_rule[i].tunnel_src && it.addr_b == policy_rule[i].tunnel_dst;
          else
            m = addr_in_rule(it.addr_a, it.addr_b, policy_rule[i]);
          if (!res.hit && m && policy_rule[i].ipsec_proto == it.ipsec_protocol) begin
            res.hit = 1'b1;
            res.match_index = ENTRY_W'(i);
            if (policy_bound[i]) begin
              res.bind_status = BIND_ALREADY;
            end else begin
              policy_bound[i] = 1'b1;
              policy_first_sa[i] = it.sa_handle;
              res.bind_status = BIND_NEW;
            end
            res.first_sa = policy_first_sa[i];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic item_t make_item(input logic [FUNC_W-1:0] func,
                                      input logic [ENTRY_W-1:0] slot,
                                      input logic [ADDR_W-1:0] a, input logic [ADDR_W-1:0] ma,
                                      input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] mb,
                                      input logic [PROTO_W-1:0] up,
                                      input logic [PROTO_W-1:0] ip, input logic md,
                                      input logic [ADDR_W-1:0] ts, input logic [ADDR_W-1:0] td,
                                      input logic [SA_W-1:0] sa);
    return '{func: func, entry_index: slot, addr_a: a, mask_a: ma, addr_b: b, mask_b: mb,
             upper_protocol: up, ipsec_protocol: ip, mode: md, tunnel_src: ts,
             tunnel_dst: td, sa_handle: sa};
  endfunction

  function automatic stim_row_t item_row(input item_t it, input bit typed, input result_t want);
    return '{kind: ROW_ITEM, item: it, typed: typed, want: want, entries: '0, any_code: '0};
  endfunction

  function automatic stim_row_t cfg_row(input logic [ENTRIES_W-1:0] entries,
                                        input logic [PROTO_W-1:0] any_code);
    return '{kind: ROW_CFG, item: '0, typed: 1'b0, want: NO_MATCH, entries: entries,
             any_code: any_code};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    if (r < 8) return ~32'h0 << (ADDR_W - $urandom_range(0, ADDR_W));
    return $urandom();
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return addr_pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return PROTO_POOL[$urandom_range(0, 3)];
    if (r < 7) return PROTO_WILDCARD;
    if (r < 8) return '0;
    return PROTO_W'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_slot();
    int unsigned n;
    n = (32'(scan_entries) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(scan_entries);
    if (n != 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, n - 1);
    return $urandom_range(0, TABLE_DEPTH - 1);
  endfunction

  function automatic item_t random_noise();
    item_t it;
    it.func = FUNC_W'($urandom_range(0, 3));
    it.entry_index = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
    it.addr_a = $urandom();
    it.mask_a = $urandom();
    it.addr_b = $urandom();
    it.mask_b = $urandom();
    it.upper_protocol = PROTO_W'($urandom_range(0, 255));
    it.ipsec_protocol = PROTO_W'($urandom_range(0, 255));
    it.mode = 1'($urandom_range(0, 1));
    it.tunnel_src = $urandom();
    it.tunnel_dst = $urandom();
    it.sa_handle = SA_W'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic item_t random_load(input logic [ENTRY_W-1:0] slot);
    item_t it;
    it = random_noise();
    it.func = FUNC_LOAD;
    it.entry_index = slot;
    it.addr_a = pick_addr();
    it.mask_a = pick_mask();
    it.addr_b = pick_addr();
    it.mask_b = pick_mask();
    it.upper_protocol = pick_proto();
    it.ipsec_protocol = pick_proto();
    it.tunnel_src = pick_addr();
    it.tunnel_dst = pick_addr();
    return it;
  endfunction

  // mostly packets and SAs aimed at a loaded rule, the rest loads, unused functions and noise
  function automatic item_t random_item();
    item_t       it;
    rule_t       r;
    int unsigned sel;
    it = random_noise();
    sel = $urandom_range(0, 99);
    r = policy_rule[ENTRY_W'(pick_slot())];
    if (sel < 15) begin
      it = random_load(ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1)));
    end else if (sel < 50) begin
      it.func = FUNC_LOOKUP;
      if (sel < 43) begin
        it.addr_a = byte_reverse((r.src & r.src_care) | (it.addr_a & ~r.src_care));
        it.addr_b = byte_reverse((r.dst & r.dst_care) | (it.addr_b & ~r.dst_care));
        if ($urandom_range(0, 2) != 0) it.upper_protocol = r.upper_proto;
      end
    end else if (sel < 90) begin
      it.func = FUNC_BIND;
      if (sel < 82) begin
        if (r.mode == TUNNEL) begin
          it.addr_a = r.tunnel_src;
          it.addr_b = r.tunnel_dst;
        end else begin
          it.addr_a = (r.src & r.src_care) | (it.addr_a & ~r.src_care);
          it.addr_b = (r.dst & r.dst_care) | (it.addr_b & ~r.dst_care);
        end
        if ($urandom_range(0, 4) != 0) it.ipsec_protocol = r.ipsec_proto;
      end
    end else if (sel < 95) begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic drive_fields(input item_t it);
    item_if.func           <= it.func;
    item_if.entry_index    <= it.entry_index;
    item_if.addr_a         <= it.addr_a;
    item_if.mask_a         <= it.mask_a;
    item_if.addr_b         <= it.addr_b;
    item_if.mask_b         <= it.mask_b;
    item_if.upper_protocol <= it.upper_protocol;
    item_if.ipsec_protocol <= it.ipsec_protocol;
    item_if.mode           <= it.mode;
    item_if.tunnel_src     <= it.tunnel_src;
    item_if.tunnel_dst     <= it.tunnel_dst;
    item_if.sa_handle      <= it.sa_handle;
  endtask

  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    drive_fields(it);
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    predicted = predict_policy(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // both registers, only once the table scan has gone quiet
  task automatic write_config(input logic [ENTRIES_W-1:0] entries,
                              input logic [PROTO_W-1:0] any_code);
    item_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ENTRIES_IN_USE;
    cfg_if.data  <= CFG_DAT_W'(entries);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    scan_entries = entries;
    cfg_if.index <= CFG_ANY_PROTOCOL;
    cfg_if.data  <= any_code;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    wildcard_proto = any_code;
    cfg_if.valid <= 1'b0;
  endtask

  initial res_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    if (rx_hold != 0) begin
      res_if.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      res_if.ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t due;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = '{hit: res_if.hit, match_index: res_if.match_index,
              bind_status: res_if.bind_status, first_sa: res_if.first_sa};
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing pending", 32'(got), '0);
      end else begin
        due = pending_results.pop_front();
        if (got.hit !== due.hit) report_mismatch("hit", 32'(got.hit), 32'(due.hit));
        if (got.match_index !== due.match_index)
          report_mismatch("match_index", 32'(got.match_index), 32'(due.match_index));
        if (got.bind_status !== due.bind_status)
          report_mismatch("bind_status", 32'(got.bind_status), 32'(due.bind_status));
        if (got.first_sa !== due.first_sa)
          report_mismatch("first_sa", 32'(got.first_sa), 32'(due.first_sa));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t            rows [$];
    logic [ENTRIES_W-1:0] entries;
    logic [PROTO_W-1:0]   any_code;
    rst_ni = 1'b0;
    item_if.valid <= 1'b0;
    drive_fields('0);
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_ENTRIES_IN_USE;
    cfg_if.data  <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      policy_rule[i] = '0;
      policy_bound[i] = 1'b0;
      policy_first_sa[i] = '0;
    end
    scan_entries = '0;
    wildcard_proto = PROTO_WILDCARD;
    foreach (addr_pool[k]) addr_pool[k] = $urandom();

    // empty scan, unused function, then a few rules and first-match corners
    rows.push_back(item_row(make_item(FUNC_LOOKUP, 4'hF, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1,
                                      '1, '1, '1), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_UNUSED, 4'hF, '1, '1, '1, '1, 8'hFF, 8'hFF, 1'b1,
                                      '1, '1, '1), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0, '0),
                            1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOAD, 4'd0, 32'h0A00_0000, 32'hFF00_0000,
                                      32'hC0A8_0000, 32'hFFFF_0000, 8'd6, 8'd50, TRANSPORT,
                                      '0, '0, '0), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOAD, 4'd1, '0, '0, '0, '0, PROTO_WILDCARD, 8'd51,
                                      TUNNEL, '1, '0, '0), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOAD, 4'd2, '1, '1, '1, '1, 8'd0, 8'hFF, TRANSPORT,
                                      '1, '1, '1), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOAD, 4'hF, '1, '1, '1, '1, 8'hFF, 8'hFF, TUNNEL,
                                      '1, '1, '1), 1'b1, NO_MATCH));
    rows.push_back(cfg_row(5'd3, PROTO_WILDCARD));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, byte_reverse(32'h0A01_0203), '0,
                                      byte_reverse(32'hC0A8_0101), '0, 8'd6, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, byte_reverse(32'h0A01_0203), '0,
                                      byte_reverse(32'hC0A8_0101), '0, 8'd17, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, 32'h0A00_0001, '0, 32'hC0A8_0001, '0,
                                      '0, 8'd50, 1'b0, '0, '0, 10'h3FF), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, 32'h0A00_0001, '0, 32'hC0A8_0001, '0,
                                      '0, 8'd50, 1'b0, '0, '0, 10'd5), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, byte_reverse(32'h0A01_0203), '0,
                                      byte_reverse(32'hC0A8_0101), '0, 8'd6, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, '1, '0, '0, '0, '0, 8'd51, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, '1, '0, '0, '0, '0, 8'd52, 1'b0,
                                      '0, '0, 10'd7), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, '1, '0, '1, '0, 8'd0, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(cfg_row(5'd3, 8'd0));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, '1, '0, '1, '0, 8'd0, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, '0, '0, '0, '0, 8'hFF, '0, 1'b0,
                                      '0, '0, '0), 1'b0, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_LOAD, 4'd0, 32'h0A00_0000, 32'hFF00_0000,
                                      32'hC0A8_0000, 32'hFFFF_0000, 8'd6, 8'd50, TRANSPORT,
                                      '0, '0, '0), 1'b1, NO_MATCH));
    rows.push_back(item_row(make_item(FUNC_BIND, '0, 32'h0A00_0001, '0, 32'hC0A8_0001, '0,
                                      '0, 8'd50, 1'b0, '0, '0, 10'h155), 1'b0, NO_MATCH));
    rows.push_back(cfg_row(5'd0, PROTO_WILDCARD));
    rows.push_back(item_row(make_item(FUNC_LOOKUP, '0, byte_reverse(32'h0A01_0203), '0,
                                      byte_reverse(32'hC0A8_0101), '0, 8'd6, '0, 1'b0,
                                      '0, '0, '0), 1'b1, NO_MATCH));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_CFG) write_config(rows[r].entries, rows[r].any_code);
      else send_item(rows[r].item, rows[r].typed, rows[r].want);
    end

    // every slot holds a rule before any wide scan
    for (int s = 0; s < TABLE_DEPTH; s++) send_item(random_load(ENTRY_W'(s)), 1'b0, NO_MATCH);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin entries = 5'd16; any_code = PROTO_WILDCARD; end
        1: begin entries = 5'd31; any_code = 8'd0; end
        2: begin entries = 5'd1; any_code = PROTO_W'($urandom_range(0, 255)); end
        3: begin entries = 5'd0; any_code = 8'hAA; end
        default: begin
          entries = ENTRIES_W'($urandom_range(0, 31));
          case ($urandom_range(0, 3))
            0, 1: any_code = PROTO_WILDCARD;
            2: any_code = PROTO_POOL[$urandom_range(0, 3)];
            default: any_code = PROTO_W'($urandom_range(0, 255));
          endcase
        end
      endcase
      write_config(entries, any_code);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, NO_MATCH);
    end

    item_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hw/rtl/ipf_pkg.sv
hw/rtl/ipf_if.sv
hw/rtl/ipf_dp.sv
hw/rtl/ipf_ctrl.sv
hw/rtl/ipsec_policy_first_match.sv
bench/ipsec_policy_first_match_tb.sv
